// ===== rtl/lvn_pkg.sv =====
// Shared constants, types and arithmetic for the lattice value noise sampler.
package lvn_pkg;

  localparam int LATTICE_BITS    = 4;
  localparam int COORD_FRAC_BITS = 16;
  localparam int VALUE_BITS      = 16;

  localparam int COORD_BITS       = 32;
  localparam int OCTAVE_BITS      = 3;
  localparam int ENTRY_INDEX_BITS = 12;
  localparam int ENTRY_VALUE_BITS = 16;
  localparam int NOISE_BITS       = 16;

  localparam int INDEX_BITS     = 3 * LATTICE_BITS;
  localparam int NUM_BANKS      = 8;
  localparam int BANK_ADDR_BITS = 3 * (LATTICE_BITS - 1);
  localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;
  localparam int LERP_BITS      = VALUE_BITS + COORD_FRAC_BITS + 2;

  typedef enum logic [0:0] {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef logic [LATTICE_BITS-1:0]     cell_t;
  typedef logic [LATTICE_BITS-2:0]     half_cell_t;
  typedef logic [COORD_FRAC_BITS-1:0]  weight_t;
  typedef logic [VALUE_BITS-1:0]       value_t;
  typedef logic [BANK_ADDR_BITS-1:0]   bank_addr_t;
  typedef logic [INDEX_BITS-1:0]       index_t;
  typedef logic [COORD_BITS-1:0]       coord_t;
  typedef logic [NOISE_BITS-1:0]       noise_t;

  typedef struct packed {
    cell_t   pos;
    weight_t frac;
  } axis_t;

  typedef struct packed {
    logic   en;
    cell_t  x;
    cell_t  y;
    cell_t  z;
    value_t value;
  } lattice_wr_t;

  typedef struct packed {
    logic  en;
    cell_t x;
    cell_t y;
    cell_t z;
  } lattice_rd_t;

  // Shift by octave with wraparound, then split into lattice cell and weight.
  function automatic axis_t split_axis(coord_t coord, logic [OCTAVE_BITS-1:0] octave);
    coord_t shifted;
    axis_t  res;
    shifted  = coord << octave;
    res.pos  = shifted[COORD_FRAC_BITS +: LATTICE_BITS];
    res.frac = shifted[COORD_FRAC_BITS-1:0];
    return res;
  endfunction

  // Upper bits of whichever of c0 and c0+1 has the given parity.
  function automatic half_cell_t bank_coord(cell_t c0, logic parity);
    cell_t c1;
    c1 = c0 + cell_t'(1);
    return (c0[0] == parity) ? c0[LATTICE_BITS-1:1] : c1[LATTICE_BITS-1:1];
  endfunction

  // Rounded blend: (a*(1-w) + b*w + half) >> F, computed as a*2^F + (b-a)*w + half.
  function automatic value_t lerp(value_t a, value_t b, weight_t w);
    logic signed [VALUE_BITS:0]  diff;
    logic signed [LERP_BITS-1:0] prod;
    logic signed [LERP_BITS-1:0] base;
    logic signed [LERP_BITS-1:0] half;
    logic signed [LERP_BITS-1:0] acc;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, w});
    base = $signed({2'b00, a, {COORD_FRAC_BITS{1'b0}}});
    half = $signed({{(LERP_BITS-COORD_FRAC_BITS){1'b0}}, 1'b1, {(COORD_FRAC_BITS-1){1'b0}}});
    acc  = base + prod + half;
    return acc[COORD_FRAC_BITS +: VALUE_BITS];
  endfunction

endpackage

// ===== rtl/lvn_if.sv =====
// Valid/ready channel interfaces for request and response words.
interface lvn_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   command;
  logic signed [lvn_pkg::COORD_BITS-1:0]  coord_x;
  logic signed [lvn_pkg::COORD_BITS-1:0]  coord_y;
  logic signed [lvn_pkg::COORD_BITS-1:0]  coord_z;
  logic [lvn_pkg::OCTAVE_BITS-1:0]        octave;
  logic [lvn_pkg::ENTRY_INDEX_BITS-1:0]   entry_index;
  logic [lvn_pkg::ENTRY_VALUE_BITS-1:0]   entry_value;

  modport source(output valid, command, coord_x, coord_y, coord_z, octave,
                 entry_index, entry_value, input ready);
  modport sink(input valid, command, coord_x, coord_y, coord_z, octave,
               entry_index, entry_value, output ready);
endinterface

interface lvn_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [lvn_pkg::NOISE_BITS-1:0]  noise_value;

  modport source(output valid, noise_value, input ready);
  modport sink(input valid, noise_value, output ready);
endinterface

// ===== rtl/lvn_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lvn_lattice_mem.sv =====
// Lattice store split into eight parity banks; returns all eight cube corners per read.
module lvn_lattice_mem (
  input  logic                 clk,
  input  lvn_pkg::lattice_wr_t wr,
  input  lvn_pkg::lattice_rd_t rd,
  output lvn_pkg::value_t      corner [lvn_pkg::NUM_BANKS]
);

  lvn_pkg::value_t bank_data [lvn_pkg::NUM_BANKS];
  logic [2:0]      par;

  always_ff @(posedge clk) begin
    if (rd.en) begin
      par <= {rd.x[0], rd.y[0], rd.z[0]};
    end
  end

  for (genvar b = 0; b < lvn_pkg::NUM_BANKS; b++) begin : g_bank
    localparam logic [2:0] B = 3'(b);
    logic                 we;
    lvn_pkg::bank_addr_t  waddr;
    lvn_pkg::bank_addr_t  raddr;

    assign we    = wr.en && ({wr.x[0], wr.y[0], wr.z[0]} == B);
    assign waddr = {wr.x[lvn_pkg::LATTICE_BITS-1:1], wr.y[lvn_pkg::LATTICE_BITS-1:1],
                    wr.z[lvn_pkg::LATTICE_BITS-1:1]};
    assign raddr = {lvn_pkg::bank_coord(rd.x, B[2]), lvn_pkg::bank_coord(rd.y, B[1]),
                    lvn_pkg::bank_coord(rd.z, B[0])};

    lvn_ram #(
      .WIDTH(lvn_pkg::VALUE_BITS),
      .DEPTH(lvn_pkg::BANK_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(wr.value),
      .re   (rd.en),
      .raddr(raddr),
      .rdata(bank_data[b])
    );

    // corner index {ix, iy, iz}: ix = 0 is the floor cell, which sits in the bank of its parity
    assign corner[b] = bank_data[B ^ par];
  end

endmodule

// ===== rtl/lattice_value_noise_sampler.sv =====
// Top level: trilinear value noise sampler over a banked 16x16x16 lattice.
// A sample word is registered through the RAM read, the x blend, the y blend and the z blend before its result shows.
// Throughput: one word per cycle while the response side does not stall; write words give no result.
// The lattice sits in eight parity banks, so all eight corners are read in the same cycle.
// Reset clears the pipeline valids; lattice contents are undefined until written.
module lattice_value_noise_sampler (
  input logic       clk,
  input logic       rst,
  lvn_req_if.sink   req,
  lvn_rsp_if.source rsp
);

  logic                 acc;
  lvn_pkg::axis_t       ax_x, ax_y, ax_z;
  lvn_pkg::index_t      idx;
  lvn_pkg::lattice_wr_t wr;
  lvn_pkg::lattice_rd_t rd;
  lvn_pkg::value_t      corner [lvn_pkg::NUM_BANKS];

  logic            v1, v2, v3;
  logic            rdy1, rdy2, rdy3, rdy4;
  lvn_pkg::weight_t w1x, w1y, w1z, w2y, w2z, w3z;
  lvn_pkg::value_t xl [4];
  lvn_pkg::value_t xl_next [4];
  lvn_pkg::value_t yl [2];
  lvn_pkg::value_t yl_next [2];
  lvn_pkg::value_t r_next;
  logic            out_valid;
  lvn_pkg::noise_t noise;

  assign rdy4 = !out_valid || rsp.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign req.ready = rdy1;
  assign acc       = req.valid && rdy1;

  assign ax_x = lvn_pkg::split_axis(req.coord_x, req.octave);
  assign ax_y = lvn_pkg::split_axis(req.coord_y, req.octave);
  assign ax_z = lvn_pkg::split_axis(req.coord_z, req.octave);
  assign idx  = lvn_pkg::index_t'(req.entry_index);

  always_comb begin
    wr.en    = acc && (req.command == lvn_pkg::CMD_WRITE);
    wr.x     = idx[2*lvn_pkg::LATTICE_BITS +: lvn_pkg::LATTICE_BITS];
    wr.y     = idx[lvn_pkg::LATTICE_BITS +: lvn_pkg::LATTICE_BITS];
    wr.z     = idx[0 +: lvn_pkg::LATTICE_BITS];
    wr.value = lvn_pkg::value_t'(req.entry_value);
    rd.en    = acc && (req.command == lvn_pkg::CMD_SAMPLE);
    rd.x     = ax_x.pos;
    rd.y     = ax_y.pos;
    rd.z     = ax_z.pos;
  end

  lvn_lattice_mem u_mem (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .corner(corner)
  );

  for (genvar n = 0; n < 4; n++) begin : g_xl
    localparam logic [1:0] N = 2'(n);
    assign xl_next[n] = lvn_pkg::lerp(corner[{1'b0, N[0], N[1]}],
                                      corner[{1'b1, N[0], N[1]}], w1x);
  end

  for (genvar n = 0; n < 2; n++) begin : g_yl
    assign yl_next[n] = lvn_pkg::lerp(xl[2*n], xl[2*n+1], w2y);
  end

  assign r_next = lvn_pkg::lerp(yl[0], yl[1], w3z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= rd.en;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      w1x <= ax_x.frac;
      w1y <= ax_y.frac;
      w1z <= ax_z.frac;
    end
    if (v1 && rdy2) begin
      xl  <= xl_next;
      w2y <= w1y;
      w2z <= w1z;
    end
    if (v2 && rdy3) begin
      yl  <= yl_next;
      w3z <= w2z;
    end
    if (v3 && rdy4) begin
      noise <= lvn_pkg::noise_t'(r_next);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.noise_value = noise;

endmodule

// ===== rtl/lvn_checker.sv =====
// Port-level checks for the noise sampler, bound to the top level.
module lvn_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           req_command,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [lvn_pkg::NOISE_BITS-1:0] rsp_noise_value
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response word dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_noise_value))
    else $error("response word changed while stalled");

  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> req_ready)
    else $error("request not ready after reset");

  a_backpressure_only: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request stalled without a stalled response");

  a_sample_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req_command == lvn_pkg::CMD_SAMPLE))
      ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
    else $error("sample word gave no result after four cycles");

endmodule

bind lattice_value_noise_sampler lvn_checker u_lvn_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_command    (req.command),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_noise_value(rsp.noise_value)
);

// ===== dv/lvn_noise_checker.sv =====
// Checker: mirrors the lattice, predicts each noise value and compares the response stream.
`timescale 1ns / 100ps

module lvn_noise_checker
  import lvn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  lvn_req_if   req,
  lvn_rsp_if   rsp,
  output int   mismatches,
  output int   pending
);

  value_t lattice_copy [1 << INDEX_BITS];
  noise_t noise_expected_q [$];
  noise_t noise_want;
  int     fail_count = 0;
  int     queue_depth = 0;

  assign mismatches = fail_count;
  assign pending    = queue_depth;

  function automatic value_t blend_rounded(value_t a, value_t b, weight_t w);
    logic [63:0] acc;
    acc = 64'(a) * ((64'd1 << COORD_FRAC_BITS) - 64'(w)) + 64'(b) * 64'(w)
        + (64'd1 << (COORD_FRAC_BITS - 1));
    return value_t'(acc >> COORD_FRAC_BITS);
  endfunction

  function automatic noise_t predict_noise(coord_t px, coord_t py, coord_t pz,
                                           logic [OCTAVE_BITS-1:0] oct);
    coord_t  sx, sy, sz;
    cell_t   x0, y0, z0, x1, y1, z1;
    weight_t wx, wy, wz;
    value_t  e00, e10, e01, e11, f0, f1;
    sx = px << oct;
    sy = py << oct;
    sz = pz << oct;
    x0 = sx[COORD_FRAC_BITS +: LATTICE_BITS];
    y0 = sy[COORD_FRAC_BITS +: LATTICE_BITS];
    z0 = sz[COORD_FRAC_BITS +: LATTICE_BITS];
    wx = sx[COORD_FRAC_BITS-1:0];
    wy = sy[COORD_FRAC_BITS-1:0];
    wz = sz[COORD_FRAC_BITS-1:0];
    x1 = x0 + cell_t'(1);
    y1 = y0 + cell_t'(1);
    z1 = z0 + cell_t'(1);
    e00 = blend_rounded(lattice_copy[{x0, y0, z0}], lattice_copy[{x1, y0, z0}], wx);
    e10 = blend_rounded(lattice_copy[{x0, y1, z0}], lattice_copy[{x1, y1, z0}], wx);
    e01 = blend_rounded(lattice_copy[{x0, y0, z1}], lattice_copy[{x1, y0, z1}], wx);
    e11 = blend_rounded(lattice_copy[{x0, y1, z1}], lattice_copy[{x1, y1, z1}], wx);
    f0  = blend_rounded(e00, e10, wy);
    f1  = blend_rounded(e01, e11, wy);
    return noise_t'(blend_rounded(f0, f1, wz));
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) begin
        if (cmd_t'(req.command) == CMD_WRITE) begin
          lattice_copy[index_t'(req.entry_index)] = value_t'(req.entry_value);
        end else begin
          noise_expected_q.push_back(predict_noise(req.coord_x, req.coord_y, req.coord_z,
                                                   req.octave));
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (noise_expected_q.size() == 0) begin
          $error("noise_value: expected none, actual %0h", rsp.noise_value);
          fail_count++;
        end else begin
          noise_want = noise_expected_q.pop_front();
          if (rsp.noise_value !== noise_want) begin
            $error("noise_value: expected %0h, actual %0h", noise_want, rsp.noise_value);
            fail_count++;
          end
        end
      end
    end
    queue_depth = noise_expected_q.size();
  end

endmodule

// ===== dv/lattice_value_noise_sampler_tb.sv =====
// Testbench top: lattice loads, directed and random noise samples, back-pressure.
`timescale 1ns / 100ps

module lattice_value_noise_sampler_tb;
  import lvn_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_WORDS = 550;
  localparam int CALM_WORDS   = 100;
  localparam int HOLD_AT      = 300;
  localparam int FILL_SPAN    = 5;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  logic idle_on;
  logic hold_go;

  lvn_req_if req_ch ();
  lvn_rsp_if rsp_ch ();

  lattice_value_noise_sampler dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  lvn_noise_checker noise_check (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .mismatches(mismatches),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_word(cmd_t cmd, coord_t x, coord_t y, coord_t z,
                           logic [OCTAVE_BITS-1:0] oct,
                           logic [ENTRY_INDEX_BITS-1:0] idx,
                           logic [ENTRY_VALUE_BITS-1:0] val);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.command     <= cmd;
    req_ch.coord_x     <= x;
    req_ch.coord_y     <= y;
    req_ch.coord_z     <= z;
    req_ch.octave      <= oct;
    req_ch.entry_index <= idx;
    req_ch.entry_value <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic write_entry(logic [ENTRY_INDEX_BITS-1:0] idx,
                             logic [ENTRY_VALUE_BITS-1:0] val);
    send_word(CMD_WRITE, $urandom, $urandom, $urandom, 3'($urandom), idx, val);
  endtask

  task automatic sample_point(coord_t x, coord_t y, coord_t z, logic [OCTAVE_BITS-1:0] oct);
    send_word(CMD_SAMPLE, x, y, z, oct, 12'($urandom), 16'($urandom));
  endtask

  // axis positions 15, 0, 1, 2, 3 of the loaded block
  function automatic cell_t span_axis(int k);
    return cell_t'(k - 1);
  endfunction

  // keep the shifted floor at 15, 0, 1 or 2 so both corners lie in the loaded block
  function automatic coord_t fit_coord(coord_t c, logic [OCTAVE_BITS-1:0] oct);
    coord_t r;
    r = c;
    r[(COORD_FRAC_BITS - int'(oct)) +: LATTICE_BITS] = span_axis($urandom_range(0, 3));
    return r;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 4))
      0, 1: return coord_t'($urandom);
      2: return coord_t'($urandom_range(0, 32'h000F_FFFF)) - coord_t'(32'h0008_0000);
      3: begin
        case ($urandom_range(0, 3))
          0: return coord_t'(32'h8000_0000);
          1: return coord_t'(32'h7FFF_FFFF);
          2: return coord_t'(32'h0000_0000);
          default: return coord_t'(32'hFFFF_FFFF);
        endcase
      end
      default: return coord_t'({16'($urandom), 16'h0000});
    endcase
  endfunction

  // receiver: random stalls plus one long hold to back up the pipeline
  initial begin
    bit held;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_go && !held) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst                <= 1'b1;
    idle_on            <= 1'b0;
    hold_go            <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.command     <= CMD_WRITE;
    req_ch.coord_x     <= '0;
    req_ch.coord_y     <= '0;
    req_ch.coord_z     <= '0;
    req_ch.octave      <= '0;
    req_ch.entry_index <= '0;
    req_ch.entry_value <= '0;
    repeat (8) @(posedge clk);
    rst     <= 1'b0;
    idle_on <= 1'b1;

    // fill a 5x5x5 block around the origin; every sample stays inside it
    for (int a = 0; a < FILL_SPAN; a++) begin
      for (int b = 0; b < FILL_SPAN; b++) begin
        for (int c = 0; c < FILL_SPAN; c++) begin
          write_entry({span_axis(a), span_axis(b), span_axis(c)}, 16'($urandom));
        end
      end
    end

    // extreme values: the 2x2 patch at y, z = 0..1 is all zero at x = 0 and all full scale at x = 1
    for (int i = 0; i < 8; i++) begin
      write_entry(12'(((i >> 2) & 1) * 256 + ((i >> 1) & 1) * 16 + (i & 1)),
                  ((i >> 2) & 1) ? 16'hFFFF : 16'h0000);
    end
    write_entry(12'hFFF, 16'hFFFF);
    sample_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 3'd0);
    sample_point(32'h0000_FFFF, 32'h0000_0000, 32'h0000_0000, 3'd0);
    sample_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 3'd0);
    sample_point(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 3'd0);
    sample_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
    sample_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 3'd0);
    sample_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3'd0);
    sample_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 3'd7);
    for (int o = 0; o < 8; o++) begin
      sample_point(32'h0000_0321, 32'hFFFF_FEAB, 32'h0000_05A5, 3'(o));
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      logic [OCTAVE_BITS-1:0] oct;
      oct = 3'($urandom);
      if (n == HOLD_AT) hold_go <= 1'b1;
      if (n == RANDOM_WORDS - CALM_WORDS) idle_on <= 1'b0;
      if ($urandom_range(0, 99) < 35) begin
        write_entry({span_axis($urandom_range(0, 4)), span_axis($urandom_range(0, 4)),
                     span_axis($urandom_range(0, 4))}, 16'($urandom));
      end else begin
        sample_point(fit_coord(rand_coord(), oct), fit_coord(rand_coord(), oct),
                     fit_coord(rand_coord(), oct), oct);
      end
    end
    req_ch.valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
